// ===== sv/drct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drct_pkg
// Shared types for the disk request checker and timer: request and response
// beats, the per-drive state read port and the state update.
// ----------------------------------------------------------------------------
package drct_pkg;

	localparam int unsigned DRIVE_COUNT = 4;
	localparam int unsigned DRIVE_W     = 2;

	// Highest legal drive number
	localparam logic [2:0] DRIVE_MAX = 3'd3;

	// Response status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [2:0] drive_number;
		logic [3:0] head_number;
		logic [8:0] cylinder_number;
		logic [5:0] start_sector;
		logic [5:0] sector_count;
	} drct_req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] linear_sector;
		logic [5:0]  rotation_wait;
		logic [8:0]  seek_distance;
		logic [5:0]  sectors_done;
	} drct_rsp_t;

	// Stored position of one drive
	typedef struct packed {
		logic [8:0] cylinder;
		logic [5:0] sector;
	} drct_pos_t;

	// Position update for one drive
	typedef struct packed {
		logic               we;
		logic [DRIVE_W-1:0] drive;
		drct_pos_t          pos;
	} drct_upd_t;

endpackage

// ===== sv/drct_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drct_state
// Four-entry register file holding each drive's last cylinder and sector.
// Read is combinational at one drive index, write lands at the clock edge.
// ----------------------------------------------------------------------------
module drct_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [drct_pkg::DRIVE_W-1:0] rd_drive,
	output drct_pkg::drct_pos_t         rd_pos,
	input  drct_pkg::drct_upd_t         upd
);
	import drct_pkg::*;

	drct_pos_t pos_q [DRIVE_COUNT];

	// Update the addressed drive's position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(DRIVE_COUNT); i++) begin
				pos_q[i] <= '0;
			end
		end else if (upd.we) begin
			pos_q[upd.drive] <= upd.pos;
		end
	end

	// Read the requested drive
	assign rd_pos = pos_q[rd_drive];

endmodule

// ===== sv/drct_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drct_calc
// Request check and timing arithmetic: validates the request, forms the
// linear sector address, rotational wait and seek distance, and the update.
// ----------------------------------------------------------------------------
module drct_calc #(
	parameter int unsigned HEAD_COUNT        = 8,
	parameter int unsigned CYLINDER_COUNT    = 256,
	parameter int unsigned SECTORS_PER_TRACK = 32
) (
	input  drct_pkg::drct_req_t req,
	input  drct_pkg::drct_pos_t last_pos,
	output drct_pkg::drct_rsp_t rsp,
	output drct_pkg::drct_upd_t upd
);
	import drct_pkg::*;

	localparam int unsigned TRACK_SPAN = SECTORS_PER_TRACK * HEAD_COUNT;
	localparam logic [6:0]  SPT7       = 7'(SECTORS_PER_TRACK);

	logic        ok;
	logic [6:0]  run_end;
	logic [6:0]  wait_full;
	logic [8:0]  seek;
	logic [31:0] lin_full;

	// Check the request fields
	assign run_end = 7'(req.start_sector) + 7'(req.sector_count);
	assign ok = (req.drive_number <= DRIVE_MAX)
		&& (32'(req.head_number) < 32'(HEAD_COUNT))
		&& (32'(req.cylinder_number) < 32'(CYLINDER_COUNT))
		&& (req.start_sector != 6'd0)
		&& (7'(req.start_sector) <= SPT7)
		&& (run_end <= SPT7 + 7'd1);

	// Rotate forward from the last sector, wrapping by one track
	assign wait_full = (req.start_sector >= last_pos.sector)
		? 7'(req.start_sector) - 7'(last_pos.sector)
		: 7'(req.start_sector) + SPT7 - 7'(last_pos.sector);

	// Seek as an absolute cylinder difference
	assign seek = (req.cylinder_number >= last_pos.cylinder)
		? req.cylinder_number - last_pos.cylinder
		: last_pos.cylinder - req.cylinder_number;

	// Form the linear address; the constant products reduce to shifts and adds
	assign lin_full = 32'(req.cylinder_number) * 32'(TRACK_SPAN)
		+ 32'(req.head_number) * 32'(SECTORS_PER_TRACK)
		+ 32'(req.start_sector) - 32'd1;

	// Drive the response, zeroed for a rejected request
	always_comb begin
		if (ok) begin
			rsp.status        = STATUS_OK;
			rsp.linear_sector = lin_full[15:0];
			rsp.rotation_wait = wait_full[5:0];
			rsp.seek_distance = seek;
			rsp.sectors_done  = req.sector_count;
		end else begin
			rsp = '0;
			rsp.status = STATUS_INVALID;
		end
	end

	// Store the new position only for an accepted request
	assign upd.we           = ok;
	assign upd.drive        = req.drive_number[DRIVE_W-1:0];
	assign upd.pos.cylinder = req.cylinder_number;
	assign upd.pos.sector   = req.start_sector;

endmodule

// ===== sv/disk_request_checker_timer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_request_checker_timer_unit
// Path: a request beat is held in the input register, then in the response
//   register, which drives the response port.
// Throughput: one request per cycle while the response port is not stalled,
//   with a read-modify-write of the four-entry drive position file per request.
// Reset: arst_n clears both stage valid flags and every drive's cylinder and sector to 0.
// ----------------------------------------------------------------------------
module disk_request_checker_timer_unit #(
	parameter int unsigned HEAD_COUNT        = 8,
	parameter int unsigned CYLINDER_COUNT    = 256,
	parameter int unsigned SECTORS_PER_TRACK = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  drct_pkg::drct_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output drct_pkg::drct_rsp_t rsp
);
	import drct_pkg::*;

	logic      valid_s1;
	drct_req_t req_s1;
	logic      valid_s2;
	drct_rsp_t rsp_s2;

	logic      advance;
	drct_pos_t last_pos;
	drct_rsp_t rsp_calc;
	drct_upd_t upd_calc;
	drct_upd_t upd;

	// Move the held request on when the response register is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Hold the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	drct_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_drive (req_s1.drive_number[DRIVE_W-1:0]),
		.rd_pos   (last_pos),
		.upd      (upd)
	);

	drct_calc #(
		.HEAD_COUNT        (HEAD_COUNT),
		.CYLINDER_COUNT    (CYLINDER_COUNT),
		.SECTORS_PER_TRACK (SECTORS_PER_TRACK)
	) u_calc (
		.req      (req_s1),
		.last_pos (last_pos),
		.rsp      (rsp_calc),
		.upd      (upd_calc)
	);

	// Commit the drive position together with the response
	always_comb begin
		upd    = upd_calc;
		upd.we = upd_calc.we && advance;
	end

	// Register the response beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_calc;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A rejected request reports all result fields as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_INVALID) |->
		(rsp.linear_sector == 16'd0 && rsp.rotation_wait == 6'd0
		&& rsp.seek_distance == 9'd0 && rsp.sectors_done == 6'd0))
		else $error("rejected request carries nonzero result");

	// A held request blocks the input while the response stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("input accepted while pipeline is full");

	// Rotational wait never exceeds one track
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_OK) |->
		(32'(rsp.rotation_wait) <= 32'(SECTORS_PER_TRACK)))
		else $error("rotational wait beyond one track");

	// The drive file is written only when a request leaves the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |=> valid_s2)
		else $error("drive position written without a response");

endmodule
